### hw/rtl/mfns_pkg.sv
package mfns_pkg;

    // default map edge length
    localparam int MAZE_SIZE_DEF = 16;

    // open-side bits of one cell
    localparam logic [3:0] SIDE_UP    = 4'h1;
    localparam logic [3:0] SIDE_RIGHT = 4'h2;
    localparam logic [3:0] SIDE_DOWN  = 4'h4;
    localparam logic [3:0] SIDE_LEFT  = 4'h8;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // input word
    typedef struct packed {
        logic       req_type;
        logic [3:0] cell_x;
        logic [3:0] cell_y;
        logic [3:0] open_sides;
        logic       cell_explored;
        logic [3:0] robot_x;
        logic [3:0] robot_y;
    } t_req;

    // result word
    typedef struct packed {
        logic       frontier_found;
        logic [3:0] frontier_x;
        logic [3:0] frontier_y;
        logic       all_explored;
    } t_rsp;

endpackage

### hw/rtl/maze_frontier_nearest_search.sv
// Nearest frontier search over a MAZE_SIZE x MAZE_SIZE maze map. A word is taken when start is
// high and busy is low. A write word stores one cell's open sides and explored flag and gives
// no result; writes outside the map are dropped. A query word scans the map in x-major order,
// one cell per cycle from two registered-read memories (sides and explored flags), and when the
// scan ends presents the nearest frontier cell (Manhattan distance to robot_x/robot_y, first in
// scan order on a tie) and the all-explored flag on o_rsp, marked by o_done high for exactly one
// cycle. The receiver cannot stall: o_done is not held.
// Neighbor flags come from a 2*MAZE_SIZE+1 deep shift line fed by the explored memory read
// MAZE_SIZE cells ahead. After reset a clearing pass over all MAZE_SIZE*MAZE_SIZE cells zeroes
// both memories, with busy high.
module maze_frontier_nearest_search #(
    parameter int MAZE_SIZE = mfns_pkg::MAZE_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mfns_pkg::t_req i_req,
    output logic           o_done,
    output mfns_pkg::t_rsp o_rsp
);
    import mfns_pkg::*;

    localparam int CELLS = MAZE_SIZE * MAZE_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + MAZE_SIZE);
    localparam int CW    = $clog2(MAZE_SIZE);
    localparam int XW    = (CW > 4) ? CW : 4;
    localparam int DW    = XW + 1;
    localparam int WL    = 2 * MAZE_SIZE;

    localparam logic [SW-1:0] S_N       = SW'(MAZE_SIZE);
    localparam logic [SW-1:0] S_CELLS   = SW'(CELLS);
    localparam logic [SW-1:0] S_END     = SW'(CELLS + MAZE_SIZE - 1);
    localparam logic [SW-1:0] S_CLR_END = SW'(CELLS - 1);
    localparam logic [CW-1:0] C_LAST    = CW'(MAZE_SIZE - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_state;

    // memories
    logic [3:0] side_mem [CELLS];
    logic       expl_mem [CELLS];

    t_state          r_state, n_state;
    logic [SW-1:0]   r_s, n_s;
    logic            r_rv, n_rv;
    logic            r_dv, n_dv;
    logic [WL-1:0]   r_win, n_win;
    logic [CW-1:0]   r_cx, n_cx;
    logic [CW-1:0]   r_cy, n_cy;
    logic [3:0]      r_rx, n_rx;
    logic [3:0]      r_ry, n_ry;
    logic            r_found, n_found;
    logic            r_all, n_all;
    logic [XW-1:0]   r_bx, n_bx;
    logic [XW-1:0]   r_by, n_by;
    logic [DW-1:0]   r_bd, n_bd;
    logic            r_done, n_done;
    t_rsp            r_rsp, n_rsp;

    logic [3:0]      r_side_q;
    logic            r_expl_q;

    logic            accept;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [3:0]      mem_wside;
    logic            mem_wexpl;
    logic [AW-1:0]   side_raddr;
    logic [AW-1:0]   expl_raddr;

    logic [WL:0]     nw;
    logic            c_expl;
    logic            frontier;
    logic [XW-1:0]   xe, ye, rxe, rye, dx, dy;
    logic [DW-1:0]   cell_dist;
    logic            take;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // write port: clearing pass or a write word inside the map
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wside = '0;
        mem_wexpl = 1'b0;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_s);
        end else if (accept && i_req.req_type == REQ_WRITE &&
                     int'(i_req.cell_x) < MAZE_SIZE && int'(i_req.cell_y) < MAZE_SIZE) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(int'(i_req.cell_x) * MAZE_SIZE + int'(i_req.cell_y));
            mem_wside = i_req.open_sides;
            mem_wexpl = i_req.cell_explored;
        end
    end

    // read addresses: explored flags run one column ahead of the sides
    assign expl_raddr = (r_s < S_CELLS) ? AW'(r_s) : '0;
    assign side_raddr = (r_s >= S_N) ? AW'(r_s - S_N) : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            side_mem[mem_waddr] <= mem_wside;
            expl_mem[mem_waddr] <= mem_wexpl;
        end
        r_side_q <= side_mem[side_raddr];
        r_expl_q <= expl_mem[expl_raddr];
    end

    // shift line view with the newest flag, cell under test sits at tap MAZE_SIZE
    assign nw     = {r_win, r_expl_q};
    assign c_expl = nw[MAZE_SIZE];

    // frontier test against in-bounds neighbors
    always_comb begin
        frontier = c_expl && (
            ((r_side_q & SIDE_UP)    != 4'h0 && r_cy != C_LAST && !nw[MAZE_SIZE-1]) ||
            ((r_side_q & SIDE_RIGHT) != 4'h0 && r_cx != C_LAST && !nw[0]) ||
            ((r_side_q & SIDE_DOWN)  != 4'h0 && r_cy != '0     && !nw[MAZE_SIZE+1]) ||
            ((r_side_q & SIDE_LEFT)  != 4'h0 && r_cx != '0     && !nw[WL]));
    end

    // manhattan distance to the robot
    always_comb begin
        xe        = XW'(r_cx);
        ye        = XW'(r_cy);
        rxe       = XW'(r_rx);
        rye       = XW'(r_ry);
        dx        = (xe > rxe) ? (xe - rxe) : (rxe - xe);
        dy        = (ye > rye) ? (ye - rye) : (rye - ye);
        cell_dist = DW'(dx) + DW'(dy);
        take      = r_dv && frontier && (!r_found || cell_dist < r_bd);
    end

    // sequencer and result update
    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_rv    = 1'b0;
        n_dv    = 1'b0;
        n_win   = r_win;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_found = r_found;
        n_all   = r_all;
        n_bx    = r_bx;
        n_by    = r_by;
        n_bd    = r_bd;
        n_done  = 1'b0;
        n_rsp   = r_rsp;

        // data from the previous read
        if (r_rv) begin
            n_win = nw[WL-1:0];
        end
        if (r_dv) begin
            if (!c_expl) begin
                n_all = 1'b0;
            end
            if (take) begin
                n_found = 1'b1;
                n_bd    = cell_dist;
                n_bx    = xe;
                n_by    = ye;
            end
            if (r_cy == C_LAST) begin
                n_cy = '0;
                n_cx = r_cx + 1'b1;
            end else begin
                n_cy = r_cy + 1'b1;
            end
        end

        case (r_state)
            ST_CLEAR: begin
                n_s = r_s + 1'b1;
                if (r_s == S_CLR_END) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && i_req.req_type == REQ_QUERY) begin
                    n_state = ST_SCAN;
                    n_s     = '0;
                    n_cx    = '0;
                    n_cy    = '0;
                    n_rx    = i_req.robot_x;
                    n_ry    = i_req.robot_y;
                    n_found = 1'b0;
                    n_all   = 1'b1;
                    n_bx    = '0;
                    n_by    = '0;
                    n_bd    = '0;
                end
            end
            ST_SCAN: begin
                n_rv = 1'b1;
                n_dv = (r_s >= S_N);
                n_s  = r_s + 1'b1;
                if (r_s == S_END) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last cell is evaluated in this cycle
                n_state              = ST_IDLE;
                n_done               = 1'b1;
                n_rsp.frontier_found = n_found;
                n_rsp.frontier_x     = n_bx[3:0];
                n_rsp.frontier_y     = n_by[3:0];
                n_rsp.all_explored   = n_all;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_s     <= '0;
            r_rv    <= 1'b0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s     <= n_s;
            r_rv    <= n_rv;
            r_dv    <= n_dv;
            r_done  <= n_done;
        end
        r_win   <= n_win;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_found <= n_found;
        r_all   <= n_all;
        r_bx    <= n_bx;
        r_by    <= n_by;
        r_bd    <= n_bd;
        r_rsp   <= n_rsp;
    end

endmodule
